// ===== rtl/core/ppclip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppclip_pkg
// Shared types, constants and arithmetic helpers of the polygon plane clipper.
// ----------------------------------------------------------------------------
package ppclip_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int ACC_W            = 68;
    localparam int CFG_IDX_W        = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 3'd5;

    localparam logic [31:0] NORMAL_Z_RST = 32'h0001_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_EDGE,
        S_FACT,
        S_DIV,
        S_SCALE,
        S_EMIT_X,
        S_EMIT_V
    } t_state;

    function automatic logic [32:0] diff33(input logic [31:0] a, input logic [31:0] b);
        diff33 = {a[31], a} - {b[31], b};
    endfunction

    function automatic logic [ACC_W-1:0] sext_acc(input logic [32:0] v);
        sext_acc = {{(ACC_W-33){v[32]}}, v};
    endfunction

    function automatic logic [63:0] sat64(input logic [ACC_W-1:0] v);
        logic [ACC_W-64:0] top;
        top = v[ACC_W-1:63];
        if ((&top) || !(|top)) begin
            sat64 = v[63:0];
        end else if (v[ACC_W-1]) begin
            sat64 = 64'h8000_0000_0000_0000;
        end else begin
            sat64 = 64'h7FFF_FFFF_FFFF_FFFF;
        end
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        mag64 = v[63] ? (64'd0 - v) : v;
    endfunction

endpackage

// ===== rtl/core/polygon_plane_clip_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_plane_clip_top
// Clips a streamed 3D polygon against one plane, one vertex per item.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries req_type and the vertex; a
// polygon opens with a priming item (its last vertex), then its vertices.
// Output channel o_out_valid / i_out_stall carries zero, one or two vertices
// per item: a crossing point first, then the vertex itself if inside.
// The user writes plane origin and normal on the i_cfg_* port while idle; the block does not enforce this.
// One item is worked at a time; all arithmetic is bit serial through one
// shift-add accumulator and one restoring divider:
//   distance dot product       3 components x 32 bits
//   edge dot product           3 components x 32 bits, only when the side changes
//   factor check, then a divide of FRAC_BITS bits unless the factor is 0 or 1
//   crossing scaling           3 components x (FRAC_BITS + 1) bits
//   then each result goes into the output register.
// Synchronous active-low reset clears the state, plane origin, previous vertex,
// count and output valid flag; the plane normal resets to (0, 0, 32'h0001_0000).
// A stalled output holds its item; the block waits for the register to free.
// ----------------------------------------------------------------------------
module polygon_plane_clip_top #(
    parameter int MAX_VERTICES = ppclip_pkg::MAX_VERTICES_DEF,
    parameter int FRAC_BITS    = ppclip_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ppclip_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                      i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_req_type,
    input  logic [31:0]                      i_vert_x,
    input  logic [31:0]                      i_vert_y,
    input  logic [31:0]                      i_vert_z,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [31:0]                      o_out_x,
    output logic [31:0]                      o_out_y,
    output logic [31:0]                      o_out_z,
    output logic                             o_is_crossing,
    output logic [7:0]                       o_out_count,
    output logic                             o_run_last
);

    localparam int AW       = ppclip_pkg::ACC_W;
    localparam int TW       = FRAC_BITS + 1;
    localparam int CAP_I    = (2 * MAX_VERTICES > 255) ? 255 : 2 * MAX_VERTICES;
    localparam logic [7:0] CAP       = 8'(CAP_I);
    localparam logic [4:0] BIT_DOT   = 5'd31;
    localparam logic [4:0] BIT_SCALE = 5'(TW - 1);
    localparam logic [4:0] BIT_DIV   = 5'(FRAC_BITS - 1);

    ppclip_pkg::t_state r_state, n_state;

    logic [31:0] r_org [3];
    logic [31:0] r_nrm [3];

    logic        r_type, n_type;
    logic [31:0] r_v [3], n_v [3];
    logic [31:0] r_prev [3], n_prev [3];
    logic [63:0] r_prev_dist, n_prev_dist;
    logic        r_prev_in, n_prev_in;
    logic [7:0]  r_count, n_count;
    logic [63:0] r_dist, n_dist;
    logic        r_cur_in, n_cur_in;
    logic [63:0] r_d, n_d;
    logic [AW-1:0] r_acc, n_acc;
    logic [AW-1:0] r_mcand, n_mcand;
    logic [31:0] r_mplier, n_mplier;
    logic [4:0]  r_bit, n_bit;
    logic [1:0]  r_comp, n_comp;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_den, n_den;
    logic [FRAC_BITS-1:0] r_q, n_q;
    logic [31:0] r_cross [3], n_cross [3];

    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_x, n_out_x;
    logic [31:0] r_out_y, n_out_y;
    logic [31:0] r_out_z, n_out_z;
    logic        r_out_cross, n_out_cross;
    logic [7:0]  r_out_cnt, n_out_cnt;
    logic        r_out_last, n_out_last;

    logic [AW-1:0] w_add;
    logic [AW-1:0] w_acc_next;
    logic [1:0]    w_nc;
    logic [63:0]   w_sat;
    logic [63:0]   w_mag_n;
    logic [63:0]   w_mag_d;
    logic [64:0]   w_sh;
    logic          w_take;
    logic [FRAC_BITS-1:0] w_q;
    logic          w_out_free;
    logic [7:0]    w_cnt_inc;

    assign o_in_stall    = (r_state != ppclip_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_out_z       = r_out_z;
    assign o_is_crossing = r_out_cross;
    assign o_out_count   = r_out_cnt;
    assign o_run_last    = r_out_last;

    assign w_add      = r_mplier[0] ? r_mcand : '0;
    assign w_acc_next = (r_state != ppclip_pkg::S_SCALE && r_bit == BIT_DOT)
                        ? r_acc - w_add : r_acc + w_add;
    assign w_nc       = (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
    assign w_sat      = ppclip_pkg::sat64(w_acc_next);
    assign w_mag_n    = ppclip_pkg::mag64(r_prev_dist);
    assign w_mag_d    = ppclip_pkg::mag64(r_d);
    assign w_sh       = {r_rem, 1'b0};
    assign w_take     = w_sh[64] || (w_sh[63:0] >= r_den);
    assign w_q        = {r_q[FRAC_BITS-2:0], w_take};
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cnt_inc  = (r_count < CAP) ? r_count + 8'd1 : r_count;

    always_comb begin
        n_state     = r_state;
        n_type      = r_type;
        n_v         = r_v;
        n_prev      = r_prev;
        n_prev_dist = r_prev_dist;
        n_prev_in   = r_prev_in;
        n_count     = r_count;
        n_dist      = r_dist;
        n_cur_in    = r_cur_in;
        n_d         = r_d;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_bit       = r_bit;
        n_comp      = r_comp;
        n_rem       = r_rem;
        n_den       = r_den;
        n_q         = r_q;
        n_cross     = r_cross;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_z     = r_out_z;
        n_out_cross = r_out_cross;
        n_out_cnt   = r_out_cnt;
        n_out_last  = r_out_last;
        case (r_state)
            ppclip_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_type   = i_req_type;
                    n_v[0]   = i_vert_x;
                    n_v[1]   = i_vert_y;
                    n_v[2]   = i_vert_z;
                    n_comp   = 2'd0;
                    n_bit    = 5'd0;
                    n_acc    = '0;
                    n_mcand  = ppclip_pkg::sext_acc(ppclip_pkg::diff33(r_org[0], i_vert_x));
                    n_mplier = r_nrm[0];
                    n_state  = ppclip_pkg::S_DIST;
                end
            end
            ppclip_pkg::S_DIST, ppclip_pkg::S_EDGE: begin
                n_acc    = w_acc_next;
                n_mcand  = {r_mcand[AW-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[31:1]};
                n_bit    = r_bit + 5'd1;
                if (r_bit == BIT_DOT) begin
                    n_bit = 5'd0;
                    if (r_comp != 2'd2) begin
                        n_comp   = w_nc;
                        n_mplier = r_nrm[w_nc];
                        if (r_state == ppclip_pkg::S_DIST) begin
                            n_mcand = ppclip_pkg::sext_acc(
                                ppclip_pkg::diff33(r_org[w_nc], r_v[w_nc]));
                        end else begin
                            n_mcand = ppclip_pkg::sext_acc(
                                ppclip_pkg::diff33(r_v[w_nc], r_prev[w_nc]));
                        end
                    end else if (r_state == ppclip_pkg::S_EDGE) begin
                        n_d     = w_sat;
                        n_state = ppclip_pkg::S_FACT;
                    end else begin
                        n_dist   = w_sat;
                        n_cur_in = w_sat[63];
                        if (!r_type) begin
                            n_prev      = r_v;
                            n_prev_dist = w_sat;
                            n_prev_in   = w_sat[63];
                            n_count     = 8'd0;
                            n_state     = ppclip_pkg::S_IDLE;
                        end else if (w_sat[63] != r_prev_in) begin
                            n_comp   = 2'd0;
                            n_acc    = '0;
                            n_mplier = r_nrm[0];
                            n_mcand  = ppclip_pkg::sext_acc(
                                ppclip_pkg::diff33(r_v[0], r_prev[0]));
                            n_state  = ppclip_pkg::S_EDGE;
                        end else begin
                            n_state = ppclip_pkg::S_EMIT_V;
                        end
                    end
                end
            end
            ppclip_pkg::S_FACT: begin
                n_comp  = 2'd0;
                n_bit   = 5'd0;
                n_acc   = '0;
                n_mcand = ppclip_pkg::sext_acc(ppclip_pkg::diff33(r_v[0], r_prev[0]));
                if (r_d == 64'd0) begin
                    n_cur_in = r_prev_in;
                    n_state  = ppclip_pkg::S_EMIT_V;
                end else if (r_prev_dist == 64'd0 || r_prev_dist[63] != r_d[63]) begin
                    n_mplier = 32'd0;
                    n_state  = ppclip_pkg::S_SCALE;
                end else if (w_mag_n >= w_mag_d) begin
                    n_mplier = 32'd1 << FRAC_BITS;
                    n_state  = ppclip_pkg::S_SCALE;
                end else begin
                    n_rem   = w_mag_n;
                    n_den   = w_mag_d;
                    n_q     = '0;
                    n_state = ppclip_pkg::S_DIV;
                end
            end
            ppclip_pkg::S_DIV: begin
                n_rem = w_take ? (w_sh[63:0] - r_den) : w_sh[63:0];
                n_q   = w_q;
                n_bit = r_bit + 5'd1;
                if (r_bit == BIT_DIV) begin
                    n_bit    = 5'd0;
                    n_mplier = 32'(w_q);
                    n_state  = ppclip_pkg::S_SCALE;
                end
            end
            ppclip_pkg::S_SCALE: begin
                n_acc    = w_acc_next;
                n_mcand  = {r_mcand[AW-2:0], 1'b0};
                n_mplier = {r_mplier[0], r_mplier[31:1]};
                n_bit    = r_bit + 5'd1;
                if (r_bit == BIT_SCALE) begin
                    n_cross[r_comp] = r_prev[r_comp] + w_acc_next[FRAC_BITS+31:FRAC_BITS];
                    n_bit  = 5'd0;
                    n_acc  = '0;
                    if (r_comp != 2'd2) begin
                        n_comp   = w_nc;
                        n_mcand  = ppclip_pkg::sext_acc(
                            ppclip_pkg::diff33(r_v[w_nc], r_prev[w_nc]));
                        // rotate the factor back into place for the next component
                        n_mplier = {r_mplier[31-FRAC_BITS:0], r_mplier[31:32-FRAC_BITS]};
                    end else begin
                        n_state = ppclip_pkg::S_EMIT_X;
                    end
                end
            end
            ppclip_pkg::S_EMIT_X: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_cross[0];
                    n_out_y     = r_cross[1];
                    n_out_z     = r_cross[2];
                    n_out_cross = 1'b1;
                    n_out_cnt   = w_cnt_inc;
                    n_out_last  = !r_cur_in;
                    n_count     = w_cnt_inc;
                    n_state     = ppclip_pkg::S_EMIT_V;
                end
            end
            ppclip_pkg::S_EMIT_V: begin
                if (!r_cur_in || w_out_free) begin
                    if (r_cur_in) begin
                        n_out_valid = 1'b1;
                        n_out_x     = r_v[0];
                        n_out_y     = r_v[1];
                        n_out_z     = r_v[2];
                        n_out_cross = 1'b0;
                        n_out_cnt   = w_cnt_inc;
                        n_out_last  = 1'b1;
                        n_count     = w_cnt_inc;
                    end
                    n_prev      = r_v;
                    n_prev_dist = r_dist;
                    n_prev_in   = r_cur_in;
                    n_state     = ppclip_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppclip_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppclip_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]    <= 32'd0;
            r_org[1]    <= 32'd0;
            r_org[2]    <= 32'd0;
            r_nrm[0]    <= 32'd0;
            r_nrm[1]    <= 32'd0;
            r_nrm[2]    <= ppclip_pkg::NORMAL_Z_RST;
            r_prev[0]   <= 32'd0;
            r_prev[1]   <= 32'd0;
            r_prev[2]   <= 32'd0;
            r_prev_dist <= 64'd0;
            r_prev_in   <= 1'b0;
            r_count     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_prev      <= n_prev;
            r_prev_dist <= n_prev_dist;
            r_prev_in   <= n_prev_in;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ppclip_pkg::CFG_ORIGIN_X: r_org[0] <= i_cfg_data;
                    ppclip_pkg::CFG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                    ppclip_pkg::CFG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                    ppclip_pkg::CFG_NORMAL_X: r_nrm[0] <= i_cfg_data;
                    ppclip_pkg::CFG_NORMAL_Y: r_nrm[1] <= i_cfg_data;
                    ppclip_pkg::CFG_NORMAL_Z: r_nrm[2] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type      <= n_type;
        r_v         <= n_v;
        r_dist      <= n_dist;
        r_cur_in    <= n_cur_in;
        r_d         <= n_d;
        r_acc       <= n_acc;
        r_mcand     <= n_mcand;
        r_mplier    <= n_mplier;
        r_bit       <= n_bit;
        r_comp      <= n_comp;
        r_rem       <= n_rem;
        r_den       <= n_den;
        r_q         <= n_q;
        r_cross     <= n_cross;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_z     <= n_out_z;
        r_out_cross <= n_out_cross;
        r_out_cnt   <= n_out_cnt;
        r_out_last  <= n_out_last;
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("emit count above cap");

    a_cross_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ppclip_pkg::S_EMIT_X |-> r_cur_in != r_prev_in)
        else $error("crossing without side change");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ppclip_pkg::S_DIV |-> r_rem < r_den)
        else $error("divider remainder out of range");

endmodule
